// ===== hdl/mrs_pkg.sv =====
`timescale 1ns / 1ps
package mrs_pkg;

	localparam int VAL_W = 24;
	localparam int RES_W = 32;
	localparam int IDX_W = 3;
	localparam int Q_W   = 5;

	localparam logic [Q_W-1:0] Q_MAX_ANTI  = 5'd9;
	localparam logic [Q_W-1:0] Q_MEAN_ALL  = 5'd10;
	localparam logic [Q_W-1:0] Q_MEAN_UP   = 5'd12;
	localparam logic [Q_W-1:0] Q_SUM_LOW   = 5'd13;
	localparam logic [Q_W-1:0] Q_SUM_UP    = 5'd14;
	localparam logic [Q_W-1:0] Q_ROW_SUM   = 5'd15;
	localparam logic [Q_W-1:0] Q_COL_MEAN  = 5'd22;
	localparam logic [Q_W-1:0] Q_CLOSEST   = 5'd23;

	typedef enum logic [2:0] {
		K_MIN,
		K_MAX,
		K_SUM,
		K_MEAN,
		K_CLOSE
	} kind_t;

	typedef enum logic [2:0] {
		R_ALL,
		R_LOW,
		R_UP,
		R_DIAG,
		R_ANTI
	} region_t;

	typedef struct packed {
		logic    valid;
		kind_t   kind;
		region_t region;
		logic    per_line;
		logic    by_col;
	} ctl_t;

	function automatic ctl_t decode(input logic [Q_W-1:0] q);
		ctl_t c;
		logic [Q_W-1:0] t;
		c = '{valid: 1'b1, kind: K_SUM, region: R_ALL, per_line: 1'b0, by_col: 1'b0};
		t = q - Q_ROW_SUM;
		priority if (q <= Q_MAX_ANTI) begin
			c.kind   = q[0] ? K_MAX : K_MIN;
			c.region = region_t'(q[3:1]);
		end else if (q <= Q_MEAN_UP) begin
			c.kind   = K_MEAN;
			c.region = region_t'(3'(q - Q_MEAN_ALL));
		end else if (q == Q_SUM_LOW) begin
			c.region = R_LOW;
		end else if (q == Q_SUM_UP) begin
			c.region = R_UP;
		end else if (q <= Q_COL_MEAN) begin
			c.per_line = 1'b1;
			c.by_col   = t[0];
			unique case (t[2:1])
				2'd0: c.kind = K_SUM;
				2'd1: c.kind = K_MIN;
				2'd2: c.kind = K_MAX;
				default: c.kind = K_MEAN;
			endcase
		end else if (q == Q_CLOSEST) begin
			c.kind = K_CLOSE;
		end else begin
			c.valid = 1'b0;
		end
		return c;
	endfunction

endpackage

// ===== hdl/mrs_ram.sv =====
`timescale 1ns / 1ps
module mrs_ram #(
	parameter int W = 24,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata_q
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end
endmodule

// ===== hdl/mrs_div.sv =====
`timescale 1ns / 1ps
module mrs_div #(
	parameter int DW   = 31,
	parameter int SIZE = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic          by_line,
	input  logic          whole,
	output logic          done,
	output logic [DW-1:0] quotient
);
	// dividend is a magnitude below 2**(DW-1); the quotient is exact floor
	localparam int CELLS = SIZE * SIZE;
	localparam int TRI   = SIZE * (SIZE + 1) / 2;
	localparam int NW    = DW - 1;
	localparam int MW    = DW + 1;
	localparam int PW    = NW + MW;
	localparam int K_LN  = NW + $clog2(SIZE);
	localparam int K_AL  = NW + $clog2(CELLS);
	localparam int K_TR  = NW + $clog2(TRI);
	localparam int SHW   = $clog2(K_AL + 1);
	localparam logic [63:0] M_LN = ((64'd1 << K_LN) + 64'(SIZE - 1)) / 64'(SIZE);
	localparam logic [63:0] M_AL = ((64'd1 << K_AL) + 64'(CELLS - 1)) / 64'(CELLS);
	localparam logic [63:0] M_TR = ((64'd1 << K_TR) + 64'(TRI - 1)) / 64'(TRI);

	logic [NW-1:0]  num_q;
	logic [MW-1:0]  rcp_q;
	logic [SHW-1:0] sh_q;
	logic [DW-1:0]  quo_q;
	logic           busy_q;
	logic           done_q;
	logic [PW-1:0]  prod;

	assign prod     = PW'(num_q) * PW'(rcp_q);
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q;
			busy_q <= start;
			if (start) begin
				num_q <= dividend[NW-1:0];
				priority if (by_line) begin
					rcp_q <= M_LN[MW-1:0];
					sh_q  <= SHW'(K_LN);
				end else if (whole) begin
					rcp_q <= M_AL[MW-1:0];
					sh_q  <= SHW'(K_AL);
				end else begin
					rcp_q <= M_TR[MW-1:0];
					sh_q  <= SHW'(K_TR);
				end
			end
			if (busy_q)
				quo_q <= DW'(prod >> sh_q);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !start)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("divider done without a running division");
endmodule

// ===== hdl/matrix_region_statistics.sv =====
`timescale 1ns / 1ps
// Holds a SIZE x SIZE matrix of signed Q16.8 values in one single-port-read RAM. A write item
// (mode 0) is ignored when row or col is not below SIZE. A query item (mode 1) walks the RAM
// at one element per cycle: a whole-matrix or region reduction walks all SIZE*SIZE elements,
// a per-line query SIZE elements per line, closest-to-mean two full walks, and every mean
// adds a reciprocal multiplication. The single RAM read port sets this pace. A new item is
// taken only once the previous query has handed its last result to the output register;
// unknown query codes give no result.
module matrix_region_statistics #(
	parameter int SIZE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [mrs_pkg::IDX_W-1:0]         row,
	input  logic [mrs_pkg::IDX_W-1:0]         col,
	input  logic signed [mrs_pkg::VAL_W-1:0]  value,
	input  logic [mrs_pkg::Q_W-1:0]           query,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mrs_pkg::RES_W-1:0]  result,
	output logic [mrs_pkg::IDX_W-1:0]         line,
	output logic                              last
);
	import mrs_pkg::*;

	localparam int CELLS = SIZE * SIZE;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(SIZE);
	localparam int SW    = VAL_W + 1 + $clog2(CELLS);
	localparam int DW2   = SW + 2;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_DIV, S_EMIT} state_t;

	state_t                   state_q;
	ctl_t                     ctl_q;
	logic [IW-1:0]            a_q, b_q;
	logic [IW-1:0]            r_s1, c_s1;
	logic                     rd_v_s1, end_s1;
	logic                     pass_q, have_q;
	logic signed [SW-1:0]     acc_q, total_q;
	logic signed [VAL_W-1:0]  best_q;
	logic [DW2-1:0]           best_d_q;
	logic [IW:0]              line_cnt_q;
	logic signed [SW-1:0]     res_q;
	logic                     out_valid_q, last_q;
	logic signed [RES_W-1:0]  result_q;
	logic [IDX_W-1:0]         line_q;

	logic                     in_acc, wen, issue, grp_end, member, better, load, emit_last;
	logic [AW-1:0]            waddr, raddr;
	logic [IW-1:0]            r_rd, c_rd;
	logic signed [VAL_W-1:0]  elem;
	logic signed [DW2-1:0]    d_raw;
	logic [DW2-1:0]           d_abs;
	logic                     div_start, div_done, neg;
	logic [SW-1:0]            div_quo, mag;
	ctl_t                     ctl_in;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign wen       = in_acc && !mode && (int'(row) < SIZE) && (int'(col) < SIZE);
	assign waddr     = AW'(row) * AW'(SIZE) + AW'(col);
	assign r_rd      = ctl_q.by_col ? b_q : a_q;
	assign c_rd      = ctl_q.by_col ? a_q : b_q;
	assign raddr     = AW'(r_rd) * AW'(SIZE) + AW'(c_rd);
	assign grp_end   = (b_q == IW'(SIZE - 1)) && (ctl_q.per_line || a_q == IW'(SIZE - 1));
	assign issue     = (state_q == S_SCAN) && !(rd_v_s1 && end_s1);
	assign ctl_in    = decode(query);

	mrs_ram #(.W(VAL_W), .D(CELLS)) u_ram (
		.clk(clk), .we(wen), .waddr(waddr), .wdata(value),
		.re(issue), .raddr(raddr), .rdata_q(elem)
	);

	always_comb begin
		unique case (ctl_q.region)
			R_LOW:   member = (c_s1 <= r_s1);
			R_UP:    member = (c_s1 >= r_s1);
			R_DIAG:  member = (c_s1 == r_s1);
			R_ANTI:  member = (c_s1 == IW'(SIZE - 1) - r_s1);
			default: member = 1'b1;
		endcase
	end

	assign better = !have_q || ((ctl_q.kind == K_MAX) ? (elem > best_q) : (elem < best_q));
	assign d_raw  = DW2'(elem) * DW2'(CELLS) - DW2'(total_q);
	assign d_abs  = d_raw[DW2-1] ? DW2'(-d_raw) : DW2'(d_raw);

	assign neg       = acc_q[SW-1];
	assign mag       = neg ? SW'(-acc_q) : SW'(acc_q);
	assign div_start = (state_q == S_FIN) && (ctl_q.kind == K_MEAN);

	mrs_div #(.DW(SW), .SIZE(SIZE)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mag),
		.by_line(ctl_q.per_line), .whole(ctl_q.region == R_ALL),
		.done(div_done), .quotient(div_quo)
	);

	assign load      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = !ctl_q.per_line || (line_cnt_q == (IW + 1)'(SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			ctl_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			pass_q      <= 1'b0;
			have_q      <= 1'b0;
			line_cnt_q  <= '0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				r_s1   <= r_rd;
				c_s1   <= c_rd;
				end_s1 <= grp_end;
				if (b_q == IW'(SIZE - 1)) begin
					b_q <= '0;
					a_q <= (a_q == IW'(SIZE - 1)) ? '0 : a_q + 1'b1;
				end else begin
					b_q <= b_q + 1'b1;
				end
			end
			if (rd_v_s1 && member) begin
				if (ctl_q.kind == K_MIN || ctl_q.kind == K_MAX) begin
					if (better) begin
						best_q <= elem;
						have_q <= 1'b1;
					end
				end else if (ctl_q.kind == K_CLOSE && pass_q) begin
					if (!have_q || d_abs < best_d_q) begin
						best_q   <= elem;
						best_d_q <= d_abs;
						have_q   <= 1'b1;
					end
				end else begin
					acc_q <= acc_q + SW'(elem);
				end
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && mode) begin
						ctl_q      <= ctl_in;
						a_q        <= '0;
						b_q        <= '0;
						pass_q     <= 1'b0;
						have_q     <= 1'b0;
						acc_q      <= '0;
						line_cnt_q <= '0;
						if (ctl_in.valid)
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_v_s1 && end_s1)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (ctl_q.kind == K_CLOSE && !pass_q) begin
						total_q <= acc_q;
						pass_q  <= 1'b1;
						have_q  <= 1'b0;
						state_q <= S_SCAN;
					end else if (ctl_q.kind == K_MEAN) begin
						state_q <= S_DIV;
					end else begin
						res_q   <= (ctl_q.kind == K_SUM) ? acc_q : SW'(best_q);
						state_q <= S_EMIT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= neg ? SW'(-$signed(div_quo)) : $signed(div_quo);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						result_q    <= RES_W'(res_q);
						line_q      <= ctl_q.per_line ? IDX_W'(line_cnt_q) : '0;
						last_q      <= emit_last;
						line_cnt_q  <= line_cnt_q + 1'b1;
						acc_q       <= '0;
						have_q      <= 1'b0;
						state_q     <= emit_last ? S_IDLE : S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign line      = line_q;
	assign last      = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) rd_v_s1 |-> $past(state_q == S_SCAN))
		else $error("RAM read outside a scan");
	assert property (@(posedge clk) disable iff (!arst_n) wen |-> state_q == S_IDLE && !rd_v_s1)
		else $error("RAM write during a query");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> state_q == S_DIV)
		else $error("division finished outside its wait");
	assert property (@(posedge clk) disable iff (!arst_n) load && emit_last |=> state_q == S_IDLE)
		else $error("query did not end after its last result");
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import mrs_pkg::*;

	localparam int N = 8;

	typedef struct {
		logic signed [RES_W-1:0] result;
		logic [IDX_W-1:0]        line;
		logic                    last;
	} stat_t;

	typedef struct {
		logic                    mode;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		logic [Q_W-1:0]          query;
		logic                    typed;
		logic signed [RES_W-1:0] typed_result;
	} item_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    mode = 1'b0;
	logic [IDX_W-1:0]        row = '0;
	logic [IDX_W-1:0]        col = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic [Q_W-1:0]          query = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [RES_W-1:0] result;
	logic [IDX_W-1:0]        line;
	logic                    last;

	matrix_region_statistics #(.SIZE(N)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .row(row), .col(col), .value(value), .query(query),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .line(line), .last(last)
	);

	always #6 clk = ~clk;

	longint  mat [N][N];
	stat_t   pending_stats[$];
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      mismatches = 0;
	int      results_seen = 0;
	int      writes_sent = 0;
	int      queries_sent = 0;

	initial begin
		#20ms;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	function automatic bit in_region(int rg, int r, int c);
		case (rg)
			R_LOW:   return c <= r;
			R_UP:    return c >= r;
			R_DIAG:  return c == r;
			R_ANTI:  return c == N - 1 - r;
			default: return 1'b1;
		endcase
	endfunction

	function automatic void expect_stat(longint v, int ln, bit lst);
		stat_t s;
		s.result = v[RES_W-1:0];
		s.line = ln[IDX_W-1:0];
		s.last = lst;
		pending_stats.push_back(s);
	endfunction

	function automatic void predict_stats(logic [Q_W-1:0] q);
		longint s, n, best, d, best_d, x, acc;
		bit     have, by_col;
		int     rg, k;
		if (q <= Q_MAX_ANTI) begin
			rg = q / 2;
			have = 0;
			best = 0;
			for (int r = 0; r < N; r++)
				for (int c = 0; c < N; c++)
					if (in_region(rg, r, c) &&
					    (!have || (q[0] ? mat[r][c] > best : mat[r][c] < best))) begin
						best = mat[r][c];
						have = 1;
					end
			expect_stat(best, 0, 1);
		end else if (q <= Q_SUM_UP) begin
			rg = (q <= Q_MEAN_UP) ? q - Q_MEAN_ALL : q - Q_SUM_LOW + 1;
			s = 0;
			n = 0;
			for (int r = 0; r < N; r++)
				for (int c = 0; c < N; c++)
					if (in_region(rg, r, c)) begin
						s += mat[r][c];
						n++;
					end
			expect_stat((q <= Q_MEAN_UP) ? s / n : s, 0, 1);
		end else if (q <= Q_COL_MEAN) begin
			k = (q - Q_ROW_SUM) / 2;
			by_col = (q - Q_ROW_SUM) % 2;
			for (int l = 0; l < N; l++) begin
				acc = 0;
				for (int i = 0; i < N; i++) begin
					x = by_col ? mat[i][l] : mat[l][i];
					if (k == 1)
						acc = (i == 0 || x < acc) ? x : acc;
					else if (k == 2)
						acc = (i == 0 || x > acc) ? x : acc;
					else
						acc += x;
				end
				if (k == 3)
					acc = acc / N;
				expect_stat(acc, l, l == N - 1);
			end
		end else if (q == Q_CLOSEST) begin
			s = 0;
			for (int r = 0; r < N; r++)
				for (int c = 0; c < N; c++)
					s += mat[r][c];
			have = 0;
			best = 0;
			best_d = 0;
			for (int r = 0; r < N; r++)
				for (int c = 0; c < N; c++) begin
					d = mat[r][c] * N * N - s;
					if (d < 0)
						d = -d;
					if (!have || d < best_d) begin
						best_d = d;
						best = mat[r][c];
						have = 1;
					end
				end
			expect_stat(best, 0, 1);
		end
	endfunction

	// called at a rising edge; leaves the item accepted at the current edge
	task automatic send_item(item_t it);
		bit acc;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		row <= it.row;
		col <= it.col;
		value <= it.value;
		query <= it.query;
		if (it.mode == 1'b0) begin
			mat[it.row][it.col] = it.value;
			writes_sent++;
		end else begin
			queries_sent++;
			if (it.typed)
				expect_stat(it.typed_result, 0, 1);
			else
				predict_stats(it.query);
		end
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
	endtask

	always @(negedge clk) begin
		stat_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d line %0d last %0d", result, line, last);
			end else begin
				e = pending_stats.pop_front();
				if (e.result !== result || e.line !== line || e.last !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							e.result, e.line, e.last, result, line, last);
				end
			end
		end
	end

	function automatic item_t wr(int r, int c, int v);
		item_t it;
		it = '{1'b0, r[IDX_W-1:0], c[IDX_W-1:0], v[VAL_W-1:0], '0, 1'b0, '0};
		return it;
	endfunction

	function automatic item_t qry(logic [Q_W-1:0] q, bit typed = 0, int v = 0);
		item_t it;
		it = '{1'b1, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
			VAL_W'($urandom), q, typed, v};
		return it;
	endfunction

	function automatic item_t rand_item();
		int v;
		case ($urandom_range(7))
			0:       v = $urandom_range(1) ? 32'h007F_FFFF : 32'hFF80_0000;
			1, 2:    v = $urandom_range(3);
			default: v = $signed($urandom) >>> 8;
		endcase
		if ($urandom_range(9) < 4)
			return wr($urandom_range(7), $urandom_range(7), v);
		return qry(Q_W'($urandom_range(31)));
	endfunction

	item_t directed[$];

	initial begin
		int idle_set[4]  = '{0, 79, 0, 11};
		int stall_set[4] = '{0, 0, 79, 11};
		int limit;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N; r++)
			for (int c = 0; c < N; c++)
				send_item(wr(r, c, 0));

		directed.push_back(wr(0, 0, -8388608));
		directed.push_back(wr(7, 7, 8388607));
		directed.push_back(qry(0, 1, -8388608));
		directed.push_back(qry(1, 1, 8388607));
		directed.push_back(qry(6, 1, -8388608));
		directed.push_back(qry(7, 1, 8388607));
		directed.push_back(qry(8, 1, 0));
		for (int q = 2; q <= 23; q++)
			if (q < 6 || q > 8)
				directed.push_back(qry(Q_W'(q)));
		directed.push_back(qry(24));
		directed.push_back(qry(31));
		foreach (directed[i])
			send_item(directed[i]);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			repeat (44)
				send_item(rand_item());
		end
		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;

		limit = 0;
		while (pending_stats.size() != 0 && limit < 100000) begin
			@(posedge clk);
			limit++;
		end
		repeat (400) @(posedge clk);
		mismatches += pending_stats.size();

		$display("%0d writes and %0d queries sent, %0d results checked",
			writes_sent, queries_sent, results_seen);
		$display("idle/stall mixes: none, sender, receiver, both");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
